[hw/rtl/dense_key_table_defines.svh]
// Assertion macros used by the dense_key_table checker.
// Depends on a clock and reset signal named clock and reset in the using scope.
`ifndef DENSE_KEY_TABLE_DEFINES_SVH
`define DENSE_KEY_TABLE_DEFINES_SVH

// same-cycle implication
`define DKT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DKT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/dkt_pkg.sv]
// Types and constants for the dense key table.
// No dependencies; used by the channel interfaces, the RTL and the checker.
package dkt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int WORD_W      = 64;
   localparam int KEY_W       = 4 * WORD_W;

   typedef enum logic [1:0] {
      K_ADD    = 2'd0,
      K_REMOVE = 2'd1,
      K_LOOKUP = 2'd2,
      K_READ   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EXISTS    = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_RANGE     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_READ_RD,
      S_READ_CAP,
      S_FINISH
   } state_type;

endpackage

[hw/rtl/dkt_channels.sv]
// Request and response channel interfaces for the dense key table.
// Depends on dkt_pkg.
interface dkt_req_if;
   import dkt_pkg::*;
   logic                 valid;
   logic                 ready;
   kind_type             kind;
   logic [WORD_W-1:0]    key_word0;
   logic [WORD_W-1:0]    key_word1;
   logic [WORD_W-1:0]    key_word2;
   logic [WORD_W-1:0]    key_word3;
   logic [IDX_W-1:0]     entry_index;

   modport source (output valid, kind, key_word0, key_word1, key_word2, key_word3,
                   entry_index, input ready);
   modport sink   (input valid, kind, key_word0, key_word1, key_word2, key_word3,
                   entry_index, output ready);
endinterface

interface dkt_rsp_if;
   import dkt_pkg::*;
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic                 present;
   logic [WORD_W-1:0]    out_word0;
   logic [WORD_W-1:0]    out_word1;
   logic [WORD_W-1:0]    out_word2;
   logic [WORD_W-1:0]    out_word3;
   logic [CNT_W-1:0]     entry_total;

   modport source (output valid, status, present, out_word0, out_word1, out_word2,
                   out_word3, entry_total, input ready);
   modport sink   (input valid, status, present, out_word0, out_word1, out_word2,
                   out_word3, entry_total, output ready);
endinterface

[hw/rtl/dkt_store.sv]
// Key storage: one write port, one registered read port, and the shared
// 256-bit key comparator on the read data. Depends on dkt_pkg.
module dkt_store (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [dkt_pkg::IDX_W-1:0] wr_addr,
   input  logic [dkt_pkg::KEY_W-1:0] wr_data,
   input  logic [dkt_pkg::IDX_W-1:0] rd_addr,
   input  logic [dkt_pkg::KEY_W-1:0] key,
   output logic [dkt_pkg::KEY_W-1:0] rd_data_ff,
   output logic                      match
);
   import dkt_pkg::*;

   logic [KEY_W-1:0] store_ff [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign match = (rd_data_ff == key);

endmodule

[hw/rtl/dense_key_table.sv]
// Top level of the dense key table: request/response channels and sequencer.
// Depends on dkt_pkg, dkt_channels (dkt_req_if, dkt_rsp_if) and dkt_store.
//
// Usage:
//   req_chan carries one request (kind, four key words, entry_index); it is
//   taken when valid and ready are both high. rsp_chan returns exactly one
//   response per request, in order, with status, present, four read words
//   and the entry count after the operation.
//   The block handles one request at a time; ready is high only while idle.
//   A finished response sits in the output register, so a new request may be
//   taken while the previous response still waits for rsp ready.
//   Scanning: entries are read one at a time through one registered read port
//   and checked by one key comparator. Add/lookup stop at a hit or scan all n
//   keys on a miss; remove scans for the key, then shifts the entries past the
//   match down. Read reads and captures one entry; full and out of range
//   skip the table. Once the response is loaded the block is idle again.
//   Reset (synchronous, active high) empties the table and drops any pending
//   response. If the receiver stalls, the response holds and the next
//   request finishes into a wait state until the output register frees up.
module dense_key_table (
   input  logic      clock,
   input  logic      reset,
   dkt_req_if.sink   req_chan,
   dkt_rsp_if.source rsp_chan
);
   import dkt_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   ptr_nxt;
   kind_type           kind_ff, kind_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   status_type         res_status_ff, res_status_in;
   logic               res_present_ff, res_present_in;
   logic [KEY_W-1:0]   res_data_ff, res_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_present_ff, rsp_present_in;
   logic [KEY_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]   rsp_total_ff, rsp_total_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [KEY_W-1:0]   wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [KEY_W-1:0]   rd_data;
   logic               match;

   dkt_store u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .key        (key_ff),
      .rd_data_ff (rd_data),
      .match      (match)
   );

   assign ptr_nxt = ptr_ff + CNT_W'(1);

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.present     = rsp_present_ff;
   assign rsp_chan.out_word0   = rsp_data_ff[WORD_W-1:0];
   assign rsp_chan.out_word1   = rsp_data_ff[2*WORD_W-1:WORD_W];
   assign rsp_chan.out_word2   = rsp_data_ff[3*WORD_W-1:2*WORD_W];
   assign rsp_chan.out_word3   = rsp_data_ff[4*WORD_W-1:3*WORD_W];
   assign rsp_chan.entry_total = rsp_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      idx_ff         <= idx_in;
      res_status_ff  <= res_status_in;
      res_present_ff <= res_present_in;
      res_data_ff    <= res_data_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_present_ff <= rsp_present_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_total_ff   <= rsp_total_in;
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      kind_in        = kind_ff;
      key_in         = key_ff;
      idx_in         = idx_ff;
      res_status_in  = res_status_ff;
      res_present_in = res_present_ff;
      res_data_in    = res_data_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_present_in = rsp_present_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_total_in   = rsp_total_ff;
      wr_en          = 1'b0;
      wr_addr        = ptr_ff[IDX_W-1:0];
      wr_data        = rd_data;
      rd_addr        = ptr_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               kind_in        = req_chan.kind;
               key_in         = {req_chan.key_word3, req_chan.key_word2,
                                 req_chan.key_word1, req_chan.key_word0};
               idx_in         = req_chan.entry_index;
               ptr_in         = '0;
               res_status_in  = ST_OK;
               res_present_in = 1'b0;
               res_data_in    = '0;
               case (req_chan.kind)
                  K_ADD: begin
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_FINISH;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  K_REMOVE, K_LOOKUP: begin
                     state_in = S_SCAN_RD;
                  end
                  K_READ: begin
                     if ({1'b0, req_chan.entry_index} >= count_ff) begin
                        res_status_in = ST_RANGE;
                        state_in      = S_FINISH;
                     end else begin
                        state_in = S_READ_RD;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            if (ptr_ff == count_ff) begin
               // key not in table
               case (kind_ff)
                  K_ADD: begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IDX_W-1:0];
                     wr_data  = key_ff;
                     count_in = count_ff + CNT_W'(1);
                  end
                  K_REMOVE: begin
                     res_status_in = ST_NOT_FOUND;
                  end
                  default: begin
                  end
               endcase
               state_in = S_FINISH;
            end else begin
               rd_addr  = ptr_ff[IDX_W-1:0];
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (match) begin
               case (kind_ff)
                  K_ADD: begin
                     res_status_in = ST_EXISTS;
                     state_in      = S_FINISH;
                  end
                  K_REMOVE: begin
                     state_in = S_SHIFT_RD;
                  end
                  default: begin
                     res_present_in = 1'b1;
                     state_in       = S_FINISH;
                  end
               endcase
            end else begin
               ptr_in   = ptr_nxt;
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            if (ptr_nxt < count_ff) begin
               rd_addr  = ptr_nxt[IDX_W-1:0];
               state_in = S_SHIFT_WR;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff[IDX_W-1:0];
            wr_data  = rd_data;
            ptr_in   = ptr_nxt;
            state_in = S_SHIFT_RD;
         end
         S_READ_RD: begin
            rd_addr  = idx_ff;
            state_in = S_READ_CAP;
         end
         S_READ_CAP: begin
            res_data_in = rd_data;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_present_in = res_present_ff;
               rsp_data_in    = res_data_ff;
               rsp_total_in   = count_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/dkt_checker.sv]
// Port-level checker for dense_key_table, bound to the top level below.
// Depends on dkt_pkg and dense_key_table_defines.svh.
`include "dense_key_table_defines.svh"

module dkt_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input dkt_pkg::status_type        rsp_status,
   input logic                       rsp_present,
   input logic [dkt_pkg::KEY_W-1:0]  rsp_data,
   input logic [dkt_pkg::CNT_W-1:0]  rsp_total
);
   import dkt_pkg::*;

   `DKT_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready after accept")
   `DKT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response dropped")
   `DKT_ASSERT_NOW(a_total_range, rsp_valid, rsp_total <= CNT_W'(TABLE_DEPTH), "count beyond depth")
   `DKT_ASSERT_NOW(a_err_zero, rsp_valid && (rsp_status != ST_OK), (rsp_data == '0) && !rsp_present, "error response carries data")

endmodule

bind dense_key_table dkt_checker u_dkt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_status  (rsp_chan.status),
   .rsp_present (rsp_chan.present),
   .rsp_data    ({rsp_chan.out_word3, rsp_chan.out_word2,
                  rsp_chan.out_word1, rsp_chan.out_word0}),
   .rsp_total   (rsp_chan.entry_total)
);
